// ===== hdl/xmodem_crc_receiver_macros.svh =====
// Assertion macros for the XMODEM-CRC receiver.
// Included by the RTL files that carry concurrent assertions.
`ifndef XMODEM_CRC_RECEIVER_MACROS_SVH
`define XMODEM_CRC_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/xcr_pkg.sv =====
// Package for the XMODEM-CRC receiver: protocol codes, state types,
// result record and the byte-wide CRC-16 update. No dependencies.
package xcr_pkg;

    // Protocol bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_C   = 8'h43;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [8:0]  NUM_SUM     = 9'd255;
    localparam logic [7:0]  ERR_SAT     = 8'hFF;
    localparam logic [7:0]  MAX_ERR_RST = 8'd3;
    localparam logic [9:0]  LAST_IX_SOH = 10'd127;
    localparam logic [9:0]  LAST_IX_STX = 10'd1023;

    // Result queue depth; an event yields up to two results
    localparam int OUT_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_NUM   = 3'd1,
        PH_CMP   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCH  = 3'd4,
        PH_CRCL  = 3'd5,
        PH_DONE  = 3'd6,
        PH_ABORT = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TIMEOUT = 2'd1,
        CMD_START   = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_COMMIT  = 2'd1,
        VERDICT_DISCARD = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        FEV_NONE   = 2'd0,
        FEV_OPEN   = 2'd1,
        FEV_CLOSE  = 2'd2,
        FEV_DELETE = 2'd3
    } fevent_t;

    typedef enum logic [1:0] {
        SS_RUNNING   = 2'd0,
        SS_COMPLETED = 2'd1,
        SS_ABORTED   = 2'd2
    } sstate_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        verdict_t   verdict;
        fevent_t    file_event;
    } res_t;

    typedef struct packed {
        logic        last;
        logic [23:0] data;
    } out_item_t;

    localparam res_t RES_NONE = '{
        tx_valid:   1'b0,
        tx_byte:    8'h00,
        data_valid: 1'b0,
        data_byte:  8'h00,
        verdict:    VERDICT_NONE,
        file_event: FEV_NONE
    };

    // CRC-16/XMODEM, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  din);
        logic [15:0] c;
        c = crc_in ^ {din, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/xmodem_crc_receiver.sv =====
// XMODEM-CRC receiver top level: event register, protocol step logic,
// result queue. Depends on xcr_pkg and xmodem_crc_receiver_macros.svh.
//
// Usage:
//  - Slave stream: one transaction per event. s_axis_tuser carries the
//    command (byte received, receive timeout, start session), s_axis_tdata
//    the received byte. Command code 3 is ignored.
//  - Master stream: one or two result transactions per event; m_axis_tlast
//    marks the final result of an event. tdata carries the reply byte to the
//    host, the tentative payload byte, the packet verdict, the file event
//    and the session state after the event.
//  - cfg_wr_en/cfg_wr_data load max_errors; write only while idle.
//  - An accepted event is held in the event register and is stepped once the
//    result queue has room; its first result is then offered from the queue.
//  - Throughput: one event per cycle while every event yields one result
//    and the sink takes one per cycle; an abort event yields two results,
//    which are offered in turn. The bound is the single output port.
//  - The step waits until the result queue has room for two results; a
//    stalled sink fills the queue and then deasserts s_axis_tready.
//  - Reset: max_errors returns to 3, the session restarts (expecting packet
//    1, no image open, zero errors) and the result queue empties.
module xmodem_crc_receiver #(
    parameter int OUT_DEPTH = xcr_pkg::OUT_DEPTH   // result queue depth, >= 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_errors
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] tx_valid, [8:1] tx_byte,
                                        // [9] data_valid, [17:10] data_byte,
                                        // [19:18] packet_verdict,
                                        // [21:20] file_event,
                                        // [23:22] session_state
    output logic        m_axis_tlast
);

    `include "xmodem_crc_receiver_macros.svh"

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(OUT_DEPTH - 2);

    // ---------------- configuration ----------------
    logic [7:0] max_errors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_errors_reg <= xcr_pkg::MAX_ERR_RST;
        else if (cfg_wr_en)
            max_errors_reg <= cfg_wr_data;
    end

    // ---------------- event register ----------------
    logic            ev_valid_reg;
    xcr_pkg::cmd_t   ev_cmd_reg;
    logic [7:0]      ev_byte_reg;
    logic            step_fire;
    logic [CNT_W-1:0] cnt_reg;

    // step needs room for two results in the queue
    assign step_fire     = ev_valid_reg && (cnt_reg <= CNT_ROOM);
    assign s_axis_tready = !ev_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (s_axis_tready)
            ev_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ev_cmd_reg  <= xcr_pkg::cmd_t'(s_axis_tuser);
            ev_byte_reg <= s_axis_tdata;
        end
    end

    // ---------------- session state ----------------
    xcr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  expected_number_reg, expected_number_next;
    logic        started_reg, started_next;
    logic [7:0]  error_count_reg, error_count_next;
    logic [9:0]  byte_index_reg, byte_index_next;
    logic        large_packet_reg, large_packet_next;
    logic [7:0]  got_number_reg, got_number_next;
    logic [7:0]  got_complement_reg, got_complement_next;
    logic [15:0] crc_running_reg, crc_running_next;
    logic [7:0]  crc_high_byte_reg, crc_high_byte_next;

    xcr_pkg::res_t res0, res1;
    logic          two_res;

    // one protocol step per event
    always_comb
    begin : step_logic
        logic [7:0]        err_inc;
        logic              abort_now;
        logic              do_fault;
        xcr_pkg::verdict_t fault_verdict;
        xcr_pkg::fevent_t  fault_fev;
        xcr_pkg::fevent_t  open_fev;
        logic [15:0]       crc_upd;
        logic [9:0]        last_ix;
        logic              pkt_ok;

        phase_next           = phase_reg;
        expected_number_next = expected_number_reg;
        started_next         = started_reg;
        error_count_next     = error_count_reg;
        byte_index_next      = byte_index_reg;
        large_packet_next    = large_packet_reg;
        got_number_next      = got_number_reg;
        got_complement_next  = got_complement_reg;
        crc_running_next     = crc_running_reg;
        crc_high_byte_next   = crc_high_byte_reg;
        res0                 = xcr_pkg::RES_NONE;
        res1                 = xcr_pkg::RES_NONE;
        two_res              = 1'b0;
        do_fault             = 1'b0;
        fault_verdict        = xcr_pkg::VERDICT_NONE;
        fault_fev            = xcr_pkg::FEV_NONE;

        err_inc   = (error_count_reg == xcr_pkg::ERR_SAT) ? xcr_pkg::ERR_SAT
                                                          : error_count_reg + 8'd1;
        abort_now = (err_inc >= max_errors_reg);
        crc_upd   = xcr_pkg::crc16_byte(crc_running_reg, ev_byte_reg);
        last_ix   = large_packet_reg ? xcr_pkg::LAST_IX_STX : xcr_pkg::LAST_IX_SOH;
        pkt_ok    = (got_number_reg == expected_number_reg)
                 && (({1'b0, got_number_reg} + {1'b0, got_complement_reg})
                     == xcr_pkg::NUM_SUM)
                 && ({crc_high_byte_reg, ev_byte_reg} == crc_running_reg);
        open_fev  = started_reg ? xcr_pkg::FEV_NONE : xcr_pkg::FEV_OPEN;

        if (ev_cmd_reg == xcr_pkg::CMD_START)
        begin
            if (phase_reg inside {xcr_pkg::PH_DATA, xcr_pkg::PH_CRCH, xcr_pkg::PH_CRCL})
                res0.verdict = xcr_pkg::VERDICT_DISCARD;
            phase_next           = xcr_pkg::PH_WAIT;
            expected_number_next = 8'd1;
            started_next         = 1'b0;
            error_count_next     = 8'd0;
            byte_index_next      = 10'd0;
            large_packet_next    = 1'b0;
            got_number_next      = 8'd0;
            got_complement_next  = 8'd0;
            crc_running_next     = 16'd0;
            crc_high_byte_next   = 8'd0;
        end
        else if (ev_cmd_reg == xcr_pkg::CMD_RSVD || phase_reg == xcr_pkg::PH_DONE
                 || phase_reg == xcr_pkg::PH_ABORT)
        begin
            // session over or unknown command: no effect
        end
        else if (ev_cmd_reg == xcr_pkg::CMD_TIMEOUT)
        begin
            if (phase_reg == xcr_pkg::PH_WAIT)
            begin
                if (!started_reg)
                begin
                    res0.tx_valid = 1'b1;
                    res0.tx_byte  = xcr_pkg::BYTE_C;
                end
                else
                begin
                    do_fault = 1'b1;
                end
            end
            else
            begin
                do_fault = 1'b1;
                if (phase_reg inside {xcr_pkg::PH_DATA, xcr_pkg::PH_CRCH, xcr_pkg::PH_CRCL})
                    fault_verdict = xcr_pkg::VERDICT_DISCARD;
            end
        end
        else
        begin
            case (phase_reg)
                xcr_pkg::PH_WAIT:
                begin
                    if (ev_byte_reg == xcr_pkg::BYTE_SOH || ev_byte_reg == xcr_pkg::BYTE_STX)
                    begin
                        large_packet_next = (ev_byte_reg == xcr_pkg::BYTE_STX);
                        byte_index_next   = 10'd0;
                        crc_running_next  = 16'd0;
                        phase_next        = xcr_pkg::PH_NUM;
                    end
                    else if (ev_byte_reg == xcr_pkg::BYTE_EOT)
                    begin
                        phase_next      = xcr_pkg::PH_DONE;
                        res0.tx_valid   = 1'b1;
                        res0.tx_byte    = xcr_pkg::BYTE_ACK;
                        res0.file_event = xcr_pkg::FEV_CLOSE;
                    end
                    else if (ev_byte_reg == xcr_pkg::BYTE_CAN)
                    begin
                        phase_next = xcr_pkg::PH_ABORT;
                    end
                    else
                    begin
                        do_fault = 1'b1;
                    end
                end
                xcr_pkg::PH_NUM:
                begin
                    got_number_next = ev_byte_reg;
                    phase_next      = xcr_pkg::PH_CMP;
                end
                xcr_pkg::PH_CMP:
                begin
                    got_complement_next = ev_byte_reg;
                    byte_index_next     = 10'd0;
                    phase_next          = xcr_pkg::PH_DATA;
                end
                xcr_pkg::PH_DATA:
                begin
                    crc_running_next = crc_upd;
                    if (byte_index_reg >= last_ix)
                    begin
                        byte_index_next = 10'd0;
                        phase_next      = xcr_pkg::PH_CRCH;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 10'd1;
                    end
                    res0.data_valid = 1'b1;
                    res0.data_byte  = ev_byte_reg;
                end
                xcr_pkg::PH_CRCH:
                begin
                    crc_high_byte_next = ev_byte_reg;
                    phase_next         = xcr_pkg::PH_CRCL;
                end
                xcr_pkg::PH_CRCL:
                begin
                    started_next = 1'b1;
                    if (pkt_ok)
                    begin
                        expected_number_next = expected_number_reg + 8'd1;
                        phase_next           = xcr_pkg::PH_WAIT;
                        res0.tx_valid        = 1'b1;
                        res0.tx_byte         = xcr_pkg::BYTE_ACK;
                        res0.verdict         = xcr_pkg::VERDICT_COMMIT;
                        res0.file_event      = open_fev;
                    end
                    else
                    begin
                        do_fault      = 1'b1;
                        fault_verdict = xcr_pkg::VERDICT_DISCARD;
                        fault_fev     = open_fev;
                    end
                end
                default:
                begin
                    // finished session phases are handled above
                end
            endcase
        end

        // error handling: NAK, or CAN CAN and delete once the limit is hit
        if (do_fault)
        begin
            error_count_next = err_inc;
            res0.tx_valid    = 1'b1;
            res0.verdict     = fault_verdict;
            res0.file_event  = fault_fev;
            if (abort_now)
            begin
                res0.tx_byte    = xcr_pkg::BYTE_CAN;
                res1.tx_valid   = 1'b1;
                res1.tx_byte    = xcr_pkg::BYTE_CAN;
                res1.file_event = xcr_pkg::FEV_DELETE;
                two_res         = 1'b1;
                phase_next      = xcr_pkg::PH_ABORT;
            end
            else
            begin
                res0.tx_byte = xcr_pkg::BYTE_NAK;
                phase_next   = xcr_pkg::PH_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= xcr_pkg::PH_WAIT;
            expected_number_reg <= 8'd1;
            started_reg         <= 1'b0;
            error_count_reg     <= 8'd0;
            byte_index_reg      <= 10'd0;
            large_packet_reg    <= 1'b0;
            got_number_reg      <= 8'd0;
            got_complement_reg  <= 8'd0;
            crc_running_reg     <= 16'd0;
            crc_high_byte_reg   <= 8'd0;
        end
        else if (step_fire)
        begin
            phase_reg           <= phase_next;
            expected_number_reg <= expected_number_next;
            started_reg         <= started_next;
            error_count_reg     <= error_count_next;
            byte_index_reg      <= byte_index_next;
            large_packet_reg    <= large_packet_next;
            got_number_reg      <= got_number_next;
            got_complement_reg  <= got_complement_next;
            crc_running_reg     <= crc_running_next;
            crc_high_byte_reg   <= crc_high_byte_next;
        end
    end

    // ---------------- result packing ----------------
    xcr_pkg::sstate_t  sstate_after;
    xcr_pkg::out_item_t item0, item1;

    always_comb
    begin
        case (phase_next)
            xcr_pkg::PH_DONE:  sstate_after = xcr_pkg::SS_COMPLETED;
            xcr_pkg::PH_ABORT: sstate_after = xcr_pkg::SS_ABORTED;
            default:           sstate_after = xcr_pkg::SS_RUNNING;
        endcase
    end

    assign item0.data = {sstate_after, res0.file_event, res0.verdict, res0.data_byte,
                         res0.data_valid, res0.tx_byte, res0.tx_valid};
    assign item0.last = !two_res;
    assign item1.data = {sstate_after, res1.file_event, res1.verdict, res1.data_byte,
                         res1.data_valid, res1.tx_byte, res1.tx_valid};
    assign item1.last = 1'b1;

    // ---------------- result queue ----------------
    xcr_pkg::out_item_t q_mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop        = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg - CNT_W'(pop);
        if (step_fire)
        begin
            wr_ptr_next = two_res ? ptr_inc(wr_ptr_inc) : wr_ptr_inc;
            cnt_next    = cnt_next + (two_res ? CNT_W'(2) : CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            q_mem[wr_ptr_reg] <= item0;
            if (two_res)
                q_mem[wr_ptr_inc] <= item1;
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = q_mem[rd_ptr_reg].data;
    assign m_axis_tlast  = q_mem[rd_ptr_reg].last;

    // ---------------- assertions ----------------
    `XCR_ASSERT_IMP(a_q_no_overflow, clk, rst_n, 1'b1,
        cnt_reg <= CNT_W'(OUT_DEPTH), "result queue count exceeds depth")
    `XCR_ASSERT_IMP(a_step_has_room, clk, rst_n, step_fire,
        cnt_reg <= CNT_ROOM, "event stepped without room for two results")
    `XCR_ASSERT_NXT(a_abort_sticky, clk, rst_n,
        phase_reg == xcr_pkg::PH_ABORT
            && !(step_fire && ev_cmd_reg == xcr_pkg::CMD_START),
        phase_reg == xcr_pkg::PH_ABORT, "aborted session left without start")
    `XCR_ASSERT_NXT(a_errors_cumulative, clk, rst_n,
        !(step_fire && ev_cmd_reg == xcr_pkg::CMD_START),
        error_count_reg >= $past(error_count_reg), "error count decreased")

endmodule
